@@ src/md5_pkg.sv @@
package md5_pkg;

    localparam logic [31:0] START_A   = 32'h67452301;
    localparam logic [31:0] START_B   = 32'hefcdab89;
    localparam logic [31:0] START_C   = 32'h98badcfe;
    localparam logic [31:0] START_D   = 32'h10325476;
    localparam logic [31:0] MARK_WORD = 32'h00000080;

    localparam logic [3:0] LEN_LO_POS = 4'd14;
    localparam logic [3:0] LEN_HI_POS = 4'd15;
    localparam logic [3:0] LAST_POS   = 4'd15;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [1:0] LAST_INDEX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        WSEL_IN,
        WSEL_MARK,
        WSEL_PAD
    } word_sel_t;

    typedef struct packed {
        logic      take_item;
        logic      write_en;
        word_sel_t wsel;
        logic      len_ok;
        logic      round_en;
        logic      fold;
        logic      out_take;
        logic      clear;
    } md5_cmd_t;

    typedef struct packed {
        logic [3:0] pos;
        logic       short_word;
        logic       round_last;
        logic       out_last;
    } md5_status_t;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index per round, mod 16
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
            2'd2: g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
            default: g = 4'((r[3:0] << 3) - r[3:0]);
        endcase
        return g;
    endfunction

endpackage

@@ src/md5_ctrl.sv @@
module md5_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               end_of_message,
    input  logic               out_ready,
    input  md5_pkg::md5_status_t status,
    output logic               in_ready,
    output logic               out_valid,
    output md5_pkg::md5_cmd_t  cmd
);

    md5_pkg::state_t state_reg, state_next;
    logic msg_end_reg, msg_end_next;     // padding phase of a message
    logic mark_pend_reg, mark_pend_next; // 0x80 word still to be written
    logic len_ok_reg, len_ok_next;       // length fits in current block
    logic len_done_reg, len_done_next;   // length words written

    always_comb
    begin
        state_next     = state_reg;
        msg_end_next   = msg_end_reg;
        mark_pend_next = mark_pend_reg;
        len_ok_next    = len_ok_reg;
        len_done_next  = len_done_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (end_of_message)
                    begin
                        msg_end_next   = 1'b1;
                        mark_pend_next = !status.short_word;
                        len_ok_next    = !(status.short_word &&
                                           status.pos == md5_pkg::LEN_LO_POS);
                        len_done_next  = 1'b0;
                    end
                    if (status.pos == md5_pkg::LAST_POS)
                        state_next = md5_pkg::ST_ROUND;
                    else if (end_of_message)
                        state_next = status.short_word ? md5_pkg::ST_PAD : md5_pkg::ST_MARK;
                end
            end
            md5_pkg::ST_MARK:
            begin
                mark_pend_next = 1'b0;
                len_ok_next    = (status.pos != md5_pkg::LEN_LO_POS);
                state_next = (status.pos == md5_pkg::LAST_POS) ? md5_pkg::ST_ROUND
                                                                : md5_pkg::ST_PAD;
            end
            md5_pkg::ST_PAD:
            begin
                if (status.pos == md5_pkg::LAST_POS)
                begin
                    if (len_ok_reg)
                        len_done_next = 1'b1;
                    else
                        len_ok_next = 1'b1;
                    state_next = md5_pkg::ST_ROUND;
                end
            end
            md5_pkg::ST_ROUND:
            begin
                if (status.round_last)
                    state_next = md5_pkg::ST_FOLD;
            end
            md5_pkg::ST_FOLD:
            begin
                if (!msg_end_reg)
                    state_next = md5_pkg::ST_IDLE;
                else if (mark_pend_reg)
                    state_next = md5_pkg::ST_MARK;
                else if (len_done_reg)
                    state_next = md5_pkg::ST_OUT;
                else
                    state_next = md5_pkg::ST_PAD;
            end
            md5_pkg::ST_OUT:
            begin
                if (out_ready && status.out_last)
                begin
                    state_next    = md5_pkg::ST_IDLE;
                    msg_end_next  = 1'b0;
                    len_done_next = 1'b0;
                end
            end
            default:
                state_next = md5_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        cmd.wsel      = md5_pkg::WSEL_IN;
        cmd.len_ok    = len_ok_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
                cmd.write_en  = in_valid;
            end
            md5_pkg::ST_MARK:
            begin
                cmd.write_en = 1'b1;
                cmd.wsel     = md5_pkg::WSEL_MARK;
            end
            md5_pkg::ST_PAD:
            begin
                cmd.write_en = 1'b1;
                cmd.wsel     = md5_pkg::WSEL_PAD;
            end
            md5_pkg::ST_ROUND:
                cmd.round_en = 1'b1;
            md5_pkg::ST_FOLD:
                cmd.fold = 1'b1;
            md5_pkg::ST_OUT:
            begin
                out_valid    = 1'b1;
                cmd.out_take = out_ready;
                cmd.clear    = out_ready && status.out_last;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            msg_end_reg   <= 1'b0;
            mark_pend_reg <= 1'b0;
            len_ok_reg    <= 1'b1;
            len_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msg_end_reg   <= msg_end_next;
            mark_pend_reg <= mark_pend_next;
            len_ok_reg    <= len_ok_next;
            len_done_reg  <= len_done_next;
        end
    end

endmodule

@@ src/md5_datapath.sv @@
module md5_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          data_word,
    input  logic [2:0]           byte_count,
    input  logic                 end_of_message,
    input  md5_pkg::md5_cmd_t    cmd,
    output md5_pkg::md5_status_t status,
    output logic [31:0]          digest_word,
    output logic [1:0]           digest_index,
    output logic                 last_word
);

    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] work_reg [4];
    logic [31:0] work_next [4];
    logic [31:0] block_reg [16];
    logic [3:0]  pos_reg, pos_next;
    logic [5:0]  round_reg, round_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [1:0]  out_idx_reg, out_idx_next;

    logic        short_word;
    logic [31:0] keep_mask;
    logic [31:0] mark_bits;
    logic [31:0] in_word;
    logic [6:0]  len_add;
    logic [31:0] block_wdata;
    logic        block_full;

    logic [31:0] f_val;
    logic [31:0] round_sum;
    logic [63:0] rot_wide;
    logic [31:0] rot_val;

    assign short_word = end_of_message && (byte_count < 3'd4);

    // final short word: keep valid bytes, 0x80 right after them
    always_comb
    begin
        case (byte_count[1:0])
            2'd0:
            begin
                keep_mask = 32'h00000000;
                mark_bits = 32'h00000080;
            end
            2'd1:
            begin
                keep_mask = 32'h000000ff;
                mark_bits = 32'h00008000;
            end
            2'd2:
            begin
                keep_mask = 32'h0000ffff;
                mark_bits = 32'h00800000;
            end
            default:
            begin
                keep_mask = 32'h00ffffff;
                mark_bits = 32'h80000000;
            end
        endcase
    end

    assign in_word = short_word ? ((data_word & keep_mask) | mark_bits) : data_word;
    assign len_add = short_word ? {2'b00, byte_count[1:0], 3'b000} : 7'd32;

    always_comb
    begin
        unique case (cmd.wsel)
            md5_pkg::WSEL_IN:   block_wdata = in_word;
            md5_pkg::WSEL_MARK: block_wdata = md5_pkg::MARK_WORD;
            md5_pkg::WSEL_PAD:
            begin
                if (cmd.len_ok && pos_reg == md5_pkg::LEN_LO_POS)
                    block_wdata = bitlen_reg[31:0];
                else if (cmd.len_ok && pos_reg == md5_pkg::LEN_HI_POS)
                    block_wdata = bitlen_reg[63:32];
                else
                    block_wdata = 32'h0;
            end
            default: block_wdata = 32'h0;
        endcase
    end

    assign block_full = cmd.write_en && (pos_reg == md5_pkg::LAST_POS);

    // one MD5 round: a, b, c, d = work_reg[0..3]
    always_comb
    begin
        case (round_reg[5:4])
            2'd0: f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1: f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
            2'd2: f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
    end

    assign round_sum = f_val + work_reg[0] + md5_pkg::round_const(round_reg)
                     + block_reg[md5_pkg::msg_index(round_reg)];
    assign rot_wide  = {round_sum, round_sum} << md5_pkg::rot_amount(round_reg);
    assign rot_val   = rot_wide[63:32];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
            work_next[i]  = work_reg[i];
        end
        pos_next     = pos_reg;
        round_next   = round_reg;
        bitlen_next  = bitlen_reg;
        out_idx_next = out_idx_reg;

        if (cmd.take_item)
            bitlen_next = bitlen_reg + {57'd0, len_add};
        if (cmd.write_en)
            pos_next = pos_reg + 4'd1;
        if (block_full)
        begin
            for (int i = 0; i < 4; i++)
                work_next[i] = chain_reg[i];
            round_next = 6'd0;
        end
        if (cmd.round_en)
        begin
            work_next[0] = work_reg[3];
            work_next[1] = work_reg[1] + rot_val;
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
            round_next   = round_reg + 6'd1;
        end
        if (cmd.fold)
        begin
            for (int i = 0; i < 4; i++)
                chain_next[i] = chain_reg[i] + work_reg[i];
        end
        if (cmd.out_take)
            out_idx_next = out_idx_reg + 2'd1;
        if (cmd.clear)
        begin
            chain_next[0] = md5_pkg::START_A;
            chain_next[1] = md5_pkg::START_B;
            chain_next[2] = md5_pkg::START_C;
            chain_next[3] = md5_pkg::START_D;
            pos_next      = 4'd0;
            bitlen_next   = 64'd0;
            out_idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= md5_pkg::START_A;
            chain_reg[1] <= md5_pkg::START_B;
            chain_reg[2] <= md5_pkg::START_C;
            chain_reg[3] <= md5_pkg::START_D;
            pos_reg      <= 4'd0;
            round_reg    <= 6'd0;
            bitlen_reg   <= 64'd0;
            out_idx_reg  <= 2'd0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= chain_next[i];
            pos_reg     <= pos_next;
            round_reg   <= round_next;
            bitlen_reg  <= bitlen_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            work_reg[i] <= work_next[i];
        if (cmd.write_en)
            block_reg[pos_reg] <= block_wdata;
    end

    assign status.pos        = pos_reg;
    assign status.short_word = short_word;
    assign status.round_last = (round_reg == md5_pkg::LAST_ROUND);
    assign status.out_last   = (out_idx_reg == md5_pkg::LAST_INDEX);

    assign digest_word  = chain_reg[out_idx_reg];
    assign digest_index = out_idx_reg;
    assign last_word    = (out_idx_reg == md5_pkg::LAST_INDEX);

endmodule

@@ src/md5_message_digest.sv @@
// MD5 digest, one message word per request. Words are taken one per cycle until
// 16 are held; the 16th starts the 64 rounds and then one chain fold.
// No new word is taken while the rounds and the fold of a block run.
// End of message: the mark and padding words and one or two compressions,
// then four digest requests, A first, one per cycle while out_ready is high.
// rst_n (async, active low) loads the MD5 starting values and clears all control.
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    // message word channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        end_of_message,
    // digest channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  digest_index,
    output logic        last_word
);

    // The controller sequences: word intake, the 0x80 mark word after a full
    // final word, zero/length padding (with a spill block when the length
    // does not fit), the 64 rounds, the chain fold and the digest output.
    md5_pkg::md5_cmd_t    cmd;
    md5_pkg::md5_status_t status;

    md5_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .end_of_message (end_of_message),
        .out_ready      (out_ready),
        .status         (status),
        .in_ready       (in_ready),
        .out_valid      (out_valid),
        .cmd            (cmd)
    );

    // The datapath holds the block buffer, chain and round registers,
    // the 64-bit bit length and the output word index.
    md5_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .end_of_message (end_of_message),
        .cmd            (cmd),
        .status         (status),
        .digest_word    (digest_word),
        .digest_index   (digest_index),
        .last_word      (last_word)
    );

endmodule

@@ dv/md5_message_digest_tb.sv @@
// One digest word as the block hands it out.
typedef struct {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
} digest_req_t;

localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
};

localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
};

// rotate amounts, indexed by 4 * (round / 16) + round % 4
localparam int MD5_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

class md5_scoreboard;
    logic [31:0] chain [4];
    logic [31:0] block_words [16];
    int unsigned fill;
    logic [63:0] bit_len;
    digest_req_t digest_q [$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        chain = MD5_IV;
        fill = 0;
        bit_len = '0;
    endfunction

    function int pending();
        return digest_q.size();
    endfunction

    function void run_rounds();
        logic [31:0] a, b, c, d, f, t;
        int g, ph, s;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++)
        begin
            ph = r / 16;
            case (ph)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = 5 * r + 1;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = 3 * r + 5;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = 7 * r;
                end
            endcase
            t = f + a + MD5_K[r] + block_words[g % 16];
            s = MD5_ROT[ph * 4 + r % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    function void absorb_word(logic [31:0] w);
        block_words[fill] = w;
        fill = (fill + 1) % 16;
        if (fill == 0)
            run_rounds();
    endfunction

    // Accepted message request: update the hash state, queue digest on end.
    function void note_request(logic [31:0] w, logic [2:0] cnt, logic eom);
        int n;
        logic [31:0] keep;
        digest_req_t d;
        n = (!eom || cnt > 3'd4) ? 4 : int'(cnt);
        if (!eom)
        begin
            bit_len += 64'd32;
            absorb_word(w);
            return;
        end
        bit_len += 64'(8 * n);
        if (n == 4)
        begin
            absorb_word(w);
            absorb_word(32'h80);
        end
        else
        begin
            keep = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
            absorb_word((w & keep) | (32'h80 << (8 * n)));
        end
        // length field no longer fits: close this block with zeros
        if (fill > 14)
            while (fill != 0)
                absorb_word(32'h0);
        while (fill < 14)
            absorb_word(32'h0);
        absorb_word(bit_len[31:0]);
        absorb_word(bit_len[63:32]);
        for (int k = 0; k < 4; k++)
        begin
            d.word = chain[k];
            d.index = 2'(k);
            d.last = (k == 3);
            digest_q.push_back(d);
        end
        restart();
    endfunction

    function void check_digest(logic [31:0] word, logic [1:0] idx, logic last);
        digest_req_t want;
        if (digest_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest request: word %h index %0d last %0b",
                         word, idx, last);
            return;
        end
        want = digest_q.pop_front();
        if (want.word !== word || want.index !== idx || want.last !== last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                         want.word, want.index, want.last, word, idx, last);
        end
    endfunction
endclass

module md5_message_digest_tb;

    // ~100 random message requests after the directed part
    localparam int RANDOM_ITEMS = 100;
    // long output hold-off that backs the block up into its input
    localparam int HOLD_CYCLES = 400;
    // cycles with no request accepted on either side before giving up
    localparam int QUIET_LIMIT = 4000;
    // worst case block work after the last digest: padding plus two compressions
    localparam int SETTLE_CYCLES = 200;

    // short and oversized byte counts inside a message are all taken as four bytes
    localparam logic [2:0] MID_COUNTS [13] = '{
        3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [1:0]  digest_index;
    logic        last_word;

    md5_scoreboard sb;
    int unsigned   items_sent;
    int            burst_left;
    bit            hold_wanted;

    md5_message_digest uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .digest_index   (digest_index),
        .last_word      (last_word)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Monitor: at each rising edge the handshake signals still hold their
    // pre-edge values, so these are exactly the requests the block took.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready)
                sb.note_request(data_word, byte_count, end_of_message);
            if (out_valid && out_ready)
                sb.check_digest(digest_word, digest_index, last_word);
        end
    end

    // Watchdog: no request accepted on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("md5_message_digest test failed");
        $finish;
    end

    // Digest receiver: stretches of always-ready, coin-flip, mostly-ready and
    // a rotating mask pattern; once, a long hold-off while the sender keeps going.
    initial
    begin
        int span, mode, step;
        logic [7:0] ready_mask;
        bit held;
        held = 0;
        step = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            ready_mask = 8'($urandom) | 8'h01;
            if (hold_wanted && !held)
            begin
                held = 1;
                mode = 4;
                span = HOLD_CYCLES;
            end
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) != 0);
                    3:
                    begin
                        out_ready <= ready_mask[step % 8];
                        step++;
                    end
                    default: out_ready <= 1'b0;
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h00000000;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // Sender pacing: bursts of random length, gaps between them; some gaps
    // are long enough to land in the middle of a compression.
    task automatic take_gap();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Offer one message request and hold it until accepted. Valid is left
    // high so a back-to-back request needs no drop in between.
    task automatic send_request(input logic [31:0] w, input logic [2:0] cnt, input logic eom);
        take_gap();
        in_valid       <= 1'b1;
        data_word      <= w;
        byte_count     <= cnt;
        end_of_message <= eom;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Mostly short messages, many around one block so the final word lands
    // near the length field, a few spanning two or three blocks.
    task automatic send_random_message();
        int len, sel;
        logic [2:0] cnt;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            len = $urandom_range(0, 5);
        else if (sel < 80)
            len = $urandom_range(12, 17);
        else
            len = $urandom_range(18, 34);
        for (int i = 0; i < len; i++)
        begin
            // occasional short or oversized count mid-message: treated as full
            cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_request(rand_word(), cnt, 1'b0);
        end
        send_request(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial
    begin
        int random_start;
        sb = new();
        items_sent = 0;
        burst_left = 1 << 20;   // directed part runs without gaps
        hold_wanted = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_word      <= '0;
        byte_count     <= '0;
        end_of_message <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, single-word messages with every final count
        // class (full, oversized, short with junk in the unused bytes).
        send_request(32'h00000000, 3'd0, 1'b1);
        send_request(32'hffffffff, 3'd4, 1'b1);
        send_request(32'h00000000, 3'd7, 1'b1);
        send_request(32'hdeadbeef, 3'd1, 1'b1);
        send_request(32'h5a5aa5a5, 3'd3, 1'b1);
        send_request(32'h12345678, 3'd2, 1'b1);
        // 13 words with odd counts, then a full final word: the marker lands
        // in the low length slot, forcing an extra padding block.
        for (int i = 0; i < 13; i++)
            send_request((i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hffffffff : $urandom,
                         MID_COUNTS[i], 1'b0);
        send_request(32'hffffffff, 3'd4, 1'b1);

        // Sender pause: let every digest drain before the random part.
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);

        // Random part, with pacing on and the long output hold-off armed.
        hold_wanted = 1;
        burst_left = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
            send_random_message();
        in_valid <= 1'b0;

        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("md5_message_digest test passed");
        else
            $display("md5_message_digest test failed");
        $finish;
    end

endmodule
